// ===== sv/h_correction_eta_defines.svh =====
// assertion macros shared by the h-correction eta block
`ifndef H_CORRECTION_ETA_DEFINES_SVH
`define H_CORRECTION_ETA_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define HCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/hce_pkg.sv =====
// shared types and constants of the h-correction eta block
package hce_pkg;

  localparam int FRAC_BITS = 16;
  localparam int RHO_W     = 31;
  localparam int MOM_W     = 32;
  localparam int EN_W      = 31;
  localparam int GAMMA_W   = 19;
  localparam int FLOOR_W   = 17;
  localparam int ETA_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 19;

  localparam int IN_DATA_W  = 320;
  localparam int OUT_DATA_W = 32;

  // divider and root widths
  localparam int VEL_QUO_W = MOM_W + FRAC_BITS;
  localparam int KE_QUO_W  = EN_W;
  localparam int A2_QUO_W  = 64;
  localparam int ROOT_W    = A2_QUO_W / 2;

  // register stages of one lane, the dividers and the root included
  localparam int LANE_LAT = VEL_QUO_W + KE_QUO_W + A2_QUO_W + ROOT_W + 7;

  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_RATIO    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_FLOOR = CFG_IDX_W'(1);

  localparam logic [GAMMA_W-1:0] GAMMA_RST = GAMMA_W'(109227);
  localparam logic [FLOOR_W-1:0] FLOOR_RST = FLOOR_W'(1);
  localparam logic [GAMMA_W-1:0] ONE_FX    = GAMMA_W'(1 << FRAC_BITS);
  localparam logic [ETA_W-1:0]   ETA_MAX   = {ETA_W{1'b1}};

  typedef struct packed {
    logic [GAMMA_W-1:0] gamma_ratio;
    logic [FLOOR_W-1:0] pressure_floor;
  } cfg_t;

  typedef struct packed {
    logic [RHO_W-1:0]        rho;
    logic signed [MOM_W-1:0] mx;
    logic signed [MOM_W-1:0] my;
    logic signed [MOM_W-1:0] mz;
    logic [EN_W-1:0]         en;
  } side_t;

  typedef struct packed {
    logic [ROOT_W-1:0]    speed;
    logic                 vel_neg;
    logic [VEL_QUO_W-1:0] vel_mag;
  } lane_res_t;

endpackage

// ===== sv/hce_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module hce_div #(
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [DEN_W+QUO_W-1:0] num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic [QUO_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int ACC_W = DEN_W + QUO_W;

  // upper part holds the partial remainder, lower part fills with quotient bits
  logic [ACC_W-1:0]  acc_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [ACC_W-1:0]  acc_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    part;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign acc_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign acc_in  = acc_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign part = acc_in[ACC_W-1 -: DEN_W+1];
    assign diff = part - {1'b0, den_in};
    assign ge   = (part >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k]  <= {(ge ? diff[DEN_W-1:0] : part[DEN_W-1:0]), acc_in[QUO_W-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign quo_o  = acc_q[QUO_W-1][QUO_W-1:0];
  assign side_o = side_q[QUO_W-1];

endmodule

// ===== sv/hce_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module hce_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [hce_pkg::A2_QUO_W-1:0] rad_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic [hce_pkg::ROOT_W-1:0]   root_o,
  output logic [SIDE_W-1:0]         side_o
);

  import hce_pkg::*;

  localparam int REM_W = ROOT_W + 4;

  logic [REM_W-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0]    root_q [ROOT_W];
  logic [A2_QUO_W-1:0]  rad_q  [ROOT_W];
  logic [SIDE_W-1:0]    side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]    rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [A2_QUO_W-1:0] rad_in;
    logic [SIDE_W-1:0]   side_in;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two radicand bits, try 4r+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[A2_QUO_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        rad_q[k]  <= {rad_in[A2_QUO_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

// ===== sv/hce_lane.sv =====
// one side of the interface: velocity and sound speed
module hce_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  hce_pkg::side_t     side_i,
  input  hce_pkg::cfg_t      cfg_i,
  output hce_pkg::lane_res_t res_o
);

  import hce_pkg::*;

  localparam int SQ_W   = 2 * MOM_W;
  localparam int PROD_W = EN_W + GAMMA_W;
  localparam int PR_W   = PROD_W - FRAC_BITS;
  localparam int GP_W   = GAMMA_W + ETA_W;

  typedef struct packed {
    logic [RHO_W-1:0] rho;
    logic [MOM_W-1:0] ax;
    logic [MOM_W-1:0] ay;
    logic [MOM_W-1:0] az;
    logic [EN_W-1:0]  en;
    logic             vel_neg;
  } vel_side_t;

  typedef struct packed {
    logic [RHO_W-1:0]     rho;
    logic [EN_W-1:0]      en;
    logic                 ovf;
    logic                 vel_neg;
    logic [VEL_QUO_W-1:0] vel_mag;
  } ke_side_t;

  typedef struct packed {
    logic                 sat;
    logic                 vel_neg;
    logic [VEL_QUO_W-1:0] vel_mag;
  } a2_side_t;

  typedef struct packed {
    logic                 vel_neg;
    logic [VEL_QUO_W-1:0] vel_mag;
  } rt_side_t;

  // front end: zero density counts as one lsb
  logic [RHO_W-1:0] rho;
  logic [MOM_W-1:0] ax, ay, az;
  vel_side_t        vs_in, vs_out;
  logic [VEL_QUO_W-1:0] vel_q;

  assign rho = (side_i.rho == '0) ? RHO_W'(1) : side_i.rho;
  assign ax  = side_i.mx[MOM_W-1] ? MOM_W'(-side_i.mx) : MOM_W'(side_i.mx);
  assign ay  = side_i.my[MOM_W-1] ? MOM_W'(-side_i.my) : MOM_W'(side_i.my);
  assign az  = side_i.mz[MOM_W-1] ? MOM_W'(-side_i.mz) : MOM_W'(side_i.mz);

  assign vs_in = '{rho: rho, ax: ax, ay: ay, az: az, en: side_i.en,
                   vel_neg: side_i.mx[MOM_W-1]};

  hce_div #(
    .DEN_W (RHO_W),
    .QUO_W (VEL_QUO_W),
    .SIDE_W($bits(vel_side_t))
  ) u_vel_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i ((RHO_W + VEL_QUO_W)'({ax, FRAC_BITS'(0)})),
    .den_i (rho),
    .side_i(vs_in),
    .quo_o (vel_q),
    .side_o(vs_out)
  );

  // squared momenta
  logic [SQ_W-1:0]      sqx_q, sqy_q, sqz_q;
  logic [RHO_W-1:0]     rho1_q;
  logic [EN_W-1:0]      en1_q;
  logic                 vn1_q;
  logic [VEL_QUO_W-1:0] vm1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q  <= SQ_W'(vs_out.ax) * SQ_W'(vs_out.ax);
      sqy_q  <= SQ_W'(vs_out.ay) * SQ_W'(vs_out.ay);
      sqz_q  <= SQ_W'(vs_out.az) * SQ_W'(vs_out.az);
      rho1_q <= vs_out.rho;
      en1_q  <= vs_out.en;
      vn1_q  <= vs_out.vel_neg;
      vm1_q  <= vel_q;
    end
  end

  // sum of squares, then check that the kinetic quotient fits the energy width
  logic [SQ_W-1:0]      sum2_q, sum3_q;
  logic [RHO_W-1:0]     rho2_q, rho3_q;
  logic [EN_W-1:0]      en2_q, en3_q;
  logic                 vn2_q, vn3_q;
  logic [VEL_QUO_W-1:0] vm2_q, vm3_q;
  logic                 ovf3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum2_q <= sqx_q + sqy_q + sqz_q;
      rho2_q <= rho1_q;
      en2_q  <= en1_q;
      vn2_q  <= vn1_q;
      vm2_q  <= vm1_q;
      ovf3_q <= (sum2_q[SQ_W-1:KE_QUO_W] >= {1'b0, rho2_q, 1'b0});
      sum3_q <= sum2_q;
      rho3_q <= rho2_q;
      en3_q  <= en2_q;
      vn3_q  <= vn2_q;
      vm3_q  <= vm2_q;
    end
  end

  ke_side_t            ks_in, ks_out;
  logic [KE_QUO_W-1:0] ke;

  assign ks_in = '{rho: rho3_q, en: en3_q, ovf: ovf3_q, vel_neg: vn3_q, vel_mag: vm3_q};

  hce_div #(
    .DEN_W (RHO_W + 1),
    .QUO_W (KE_QUO_W),
    .SIDE_W($bits(ke_side_t))
  ) u_ke_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (sum3_q[RHO_W+KE_QUO_W:0]),
    .den_i ({rho3_q, 1'b0}),
    .side_i(ks_in),
    .quo_o (ke),
    .side_o(ks_out)
  );

  // pressure: (E - kinetic)*(gamma - 1), floored and capped
  logic               gam_pos;
  logic [GAMMA_W-1:0] gm1;
  logic [EN_W-1:0]    diff_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PR_W-1:0]    pr;
  logic [PR_W-1:0]    pfl;
  logic [ETA_W-1:0]   p_q;
  logic [GP_W-1:0]    gp_q;
  logic [RHO_W-1:0]   rho5_q, rho6_q, rho7_q, rho8_q;
  logic               vn5_q, vn6_q, vn7_q, vn8_q;
  logic [VEL_QUO_W-1:0] vm5_q, vm6_q, vm7_q, vm8_q;

  assign gam_pos = (cfg_i.gamma_ratio > ONE_FX);
  assign gm1     = cfg_i.gamma_ratio - ONE_FX;
  assign pr      = prod_q[PROD_W-1:FRAC_BITS];
  assign pfl     = (pr < PR_W'(cfg_i.pressure_floor)) ? PR_W'(cfg_i.pressure_floor) : pr;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= (!ks_out.ovf && (ke < ks_out.en) && gam_pos) ? (ks_out.en - ke) : '0;
      rho5_q <= ks_out.rho;
      vn5_q  <= ks_out.vel_neg;
      vm5_q  <= ks_out.vel_mag;

      prod_q <= PROD_W'(diff_q) * PROD_W'(gm1);
      rho6_q <= rho5_q;
      vn6_q  <= vn5_q;
      vm6_q  <= vm5_q;

      p_q    <= (pfl > PR_W'(ETA_MAX)) ? ETA_MAX : pfl[ETA_W-1:0];
      rho7_q <= rho6_q;
      vn7_q  <= vn6_q;
      vm7_q  <= vm6_q;

      gp_q   <= GP_W'(cfg_i.gamma_ratio) * GP_W'(p_q);
      rho8_q <= rho7_q;
      vn8_q  <= vn7_q;
      vm8_q  <= vm7_q;
    end
  end

  // a^2 = gamma*p*2^F / rho, saturating when the quotient passes 64 bits
  a2_side_t            as_in, as_out;
  logic [A2_QUO_W-1:0] a2_q;
  logic [A2_QUO_W-1:0] rad;

  assign as_in = '{sat: (RHO_W'(gp_q[GP_W-1:A2_QUO_W-FRAC_BITS]) >= rho8_q),
                   vel_neg: vn8_q, vel_mag: vm8_q};

  hce_div #(
    .DEN_W (RHO_W),
    .QUO_W (A2_QUO_W),
    .SIDE_W($bits(a2_side_t))
  ) u_a2_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i ((RHO_W + A2_QUO_W)'({gp_q, FRAC_BITS'(0)})),
    .den_i (rho8_q),
    .side_i(as_in),
    .quo_o (a2_q),
    .side_o(as_out)
  );

  assign rad = as_out.sat ? '1 : a2_q;

  rt_side_t          rs_out;
  logic [ROOT_W-1:0] root;

  hce_isqrt #(
    .SIDE_W($bits(rt_side_t))
  ) u_isqrt (
    .clk_i (clk_i),
    .en_i  (en_i),
    .rad_i (rad),
    .side_i(rt_side_t'({as_out.vel_neg, as_out.vel_mag})),
    .root_o(root),
    .side_o(rs_out)
  );

  assign res_o = '{speed: root, vel_neg: rs_out.vel_neg, vel_mag: rs_out.vel_mag};

endmodule

// ===== sv/h_correction_eta.sv =====
// Computes the H-correction eta of one cell interface per transfer from the left and right
// states (Q15.16). The block takes one interface per clock cycle unless the output stalls;
// the pipeline is made of the dividers (velocity, kinetic energy, squared sound speed,
// one quotient bit per stage), further lane registers and the 32-stage square root in
// each of the two side lanes, followed by a two-stage merge and the output register.
// A stalled output holds the whole pipeline. Configuration writes are taken every cycle and
// must only happen while no interface is in flight; unknown register indexes are ignored.
module h_correction_eta (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // density_left, density_right, mom_x_left, mom_x_right, mom_y_left, mom_y_right,
  // mom_z_left, mom_z_right, energy_left, energy_right, zero pad
  input  logic [hce_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // eta_value, zero pad
  output logic [hce_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hce_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hce_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  import hce_pkg::*;

  `include "h_correction_eta_defines.svh"

  localparam int V_W = VEL_QUO_W + 1;
  localparam int D_W = V_W + 2;

  // configuration registers
  logic [GAMMA_W-1:0] gamma_q;
  logic [FLOOR_W-1:0] floor_q;
  cfg_t               cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_RST;
      floor_q <= FLOOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAMMA_RATIO:    gamma_q <= cfg_data_i[GAMMA_W-1:0];
        REG_PRESSURE_FLOOR: floor_q <= cfg_data_i[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{gamma_ratio: gamma_q, pressure_floor: floor_q};

  // pipeline advance, whole datapath moves together
  logic adv;
  logic out_vld_q;
  logic [LANE_LAT+1:0] vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[LANE_LAT:0], s_axis_tvalid};
      out_vld_q <= vld_q[LANE_LAT+1];
    end
  end

  // unpack the transfer
  side_t side_l, side_r;

  assign side_l.rho = s_axis_tdata[30:0];
  assign side_r.rho = s_axis_tdata[61:31];
  assign side_l.mx  = s_axis_tdata[93:62];
  assign side_r.mx  = s_axis_tdata[125:94];
  assign side_l.my  = s_axis_tdata[157:126];
  assign side_r.my  = s_axis_tdata[189:158];
  assign side_l.mz  = s_axis_tdata[221:190];
  assign side_r.mz  = s_axis_tdata[253:222];
  assign side_l.en  = s_axis_tdata[284:254];
  assign side_r.en  = s_axis_tdata[315:285];

  lane_res_t res_l, res_r;

  hce_lane u_lane_l (
    .clk_i (clk_i),
    .en_i  (adv),
    .side_i(side_l),
    .cfg_i (cfg),
    .res_o (res_l)
  );

  hce_lane u_lane_r (
    .clk_i (clk_i),
    .en_i  (adv),
    .side_i(side_r),
    .cfg_i (cfg),
    .res_o (res_r)
  );

  // merge: d = v_r - v_l + a_r + a_l, eta = |d| / 2
  logic signed [V_W-1:0]   vel_l, vel_r;
  logic signed [V_W:0]     vdiff_q;
  logic [ROOT_W:0]         asum_q;
  logic signed [D_W-1:0]   d_q;
  logic [D_W-1:0]          dmag;
  logic [D_W-2:0]          half;
  logic [ETA_W-1:0]        eta_q;

  assign vel_l = res_l.vel_neg ? -$signed({1'b0, res_l.vel_mag}) : $signed({1'b0, res_l.vel_mag});
  assign vel_r = res_r.vel_neg ? -$signed({1'b0, res_r.vel_mag}) : $signed({1'b0, res_r.vel_mag});
  assign dmag  = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
  assign half  = dmag[D_W-1:1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vdiff_q <= (V_W+1)'(vel_r) - (V_W+1)'(vel_l);
      asum_q  <= (ROOT_W+1)'(res_l.speed) + (ROOT_W+1)'(res_r.speed);
      d_q     <= D_W'(vdiff_q) + $signed(D_W'(asum_q));
      eta_q   <= (half > (D_W-1)'(ETA_MAX)) ? ETA_MAX : half[ETA_W-1:0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(eta_q);

  `HCE_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !out_vld_q, s_axis_tready,
                   "input not ready while output register is empty")
  `HCE_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, vld_q[0],
                   "accepted transfer missing from pipeline")
  `HCE_ASSERT_NEXT(a_stall_freezes, clk_i, rst_ni, out_vld_q && !m_axis_tready,
                   $stable(vld_q) && out_vld_q,
                   "pipeline moved during output stall")

endmodule

// ===== tb/sv/tb_h_correction_eta.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the h-correction eta block with random stalls on both streams
module tb_h_correction_eta;
  import hce_pkg::*;

  localparam int HOLD_CYCLES = 700;
  localparam int WDOG_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 250;
  localparam int RAND_ITEMS  = 245;

  typedef struct {
    logic [RHO_W-1:0] rho_l, rho_r;
    logic [MOM_W-1:0] mx_l, mx_r, my_l, my_r, mz_l, mz_r;
    logic [EN_W-1:0]  en_l, en_r;
  } iface_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
  } reg_wr_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]  cfg_data_i = '0;

  h_correction_eta dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  iface_t              iface_q[$];
  logic [ETA_W-1:0]    eta_q[$];
  iface_t              cur_iface;
  logic [GAMMA_W-1:0]  gamma_cur = GAMMA_RST;
  logic [FLOOR_W-1:0]  floor_cur = FLOOR_RST;
  int unsigned         src_idle = 0, sink_idle = 0;
  int unsigned         hold_req = 0, hold_seen = 0, hold_left = 0;
  int unsigned         err_cnt = 0, quiet_cycles = 0;

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint side_velocity(logic [MOM_W-1:0] m, longint unsigned rho);
    longint          ms = longint'($signed(m));
    longint unsigned q  = (abs64(ms) << FRAC_BITS) / rho;
    return ms < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned side_sound_speed(longint unsigned rho,
      logic [MOM_W-1:0] mx, logic [MOM_W-1:0] my, logic [MOM_W-1:0] mz,
      longint unsigned en);
    longint unsigned ax = abs64(longint'($signed(mx)));
    longint unsigned ay = abs64(longint'($signed(my)));
    longint unsigned az = abs64(longint'($signed(mz)));
    longint unsigned sq = ax * ax + ay * ay + az * az; // wraps at 64 bits
    longint unsigned ke = sq / (2 * rho);
    longint          gm1 = longint'(gamma_cur) - (longint'(1) << FRAC_BITS);
    longint unsigned p = 0, gp, q, r, a2;
    if (ke < en && gm1 > 0) p = ((en - ke) * longint'(gm1)) >> FRAC_BITS;
    if (p < floor_cur) p = floor_cur;
    if (p > ETA_MAX) p = ETA_MAX;
    gp = longint'(gamma_cur) * p;
    q  = gp / rho;
    r  = gp % rho;
    if (q > (64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS)) a2 = 64'hFFFF_FFFF_FFFF_FFFF;
    else a2 = (q << FRAC_BITS) + (r << FRAC_BITS) / rho;
    return isqrt(a2);
  endfunction

  function automatic logic [ETA_W-1:0] predict_eta(iface_t it);
    longint unsigned rl = (it.rho_l == 0) ? 1 : it.rho_l;
    longint unsigned rr = (it.rho_r == 0) ? 1 : it.rho_r;
    longint unsigned al = side_sound_speed(rl, it.mx_l, it.my_l, it.mz_l, it.en_l);
    longint unsigned ar = side_sound_speed(rr, it.mx_r, it.my_r, it.mz_r, it.en_r);
    longint          d  = side_velocity(it.mx_r, rr) - side_velocity(it.mx_l, rl)
                          + longint'(ar) + longint'(al);
    longint unsigned e  = abs64(d) >> 1;
    if (e > ETA_MAX) e = ETA_MAX;
    return e[ETA_W-1:0];
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_iface(iface_t it);
    return IN_DATA_W'({it.en_r, it.en_l, it.mz_r, it.mz_l, it.my_r, it.my_l,
                       it.mx_r, it.mx_l, it.rho_r, it.rho_l});
  endfunction

  function automatic iface_t make_iface(logic [RHO_W-1:0] rho, logic [MOM_W-1:0] mx,
      logic [MOM_W-1:0] my, logic [MOM_W-1:0] mz, logic [EN_W-1:0] en);
    iface_t it;
    it.rho_l = rho; it.rho_r = rho;
    it.mx_l = mx;   it.mx_r = -mx;
    it.my_l = my;   it.my_r = my;
    it.mz_l = mz;   it.mz_r = mz;
    it.en_l = en;   it.en_r = en;
    return it;
  endfunction

  function automatic logic [MOM_W-1:0] small_mom(int unsigned span);
    return MOM_W'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic iface_t random_iface();
    iface_t it;
    if ($urandom_range(3) == 0) begin
      // raw noise across all bits
      it.rho_l = RHO_W'($urandom); it.rho_r = RHO_W'($urandom);
      it.mx_l = $urandom;  it.mx_r = $urandom;
      it.my_l = $urandom;  it.my_r = $urandom;
      it.mz_l = $urandom;  it.mz_r = $urandom;
      it.en_l = EN_W'($urandom);  it.en_r = EN_W'($urandom);
    end else begin
      // physical states, so the pressure term is positive most of the time
      it.rho_l = RHO_W'($urandom_range(1, 1 << $urandom_range(4, 24)));
      it.rho_r = RHO_W'($urandom_range(1, 1 << $urandom_range(4, 24)));
      it.mx_l = small_mom(1 << $urandom_range(2, 22));
      it.mx_r = small_mom(1 << $urandom_range(2, 22));
      it.my_l = small_mom(1 << $urandom_range(2, 20));
      it.my_r = small_mom(1 << $urandom_range(2, 20));
      it.mz_l = small_mom(1 << $urandom_range(2, 20));
      it.mz_r = small_mom(1 << $urandom_range(2, 20));
      it.en_l = EN_W'($urandom_range(0, 1 << $urandom_range(8, 30)));
      it.en_r = EN_W'($urandom_range(0, 1 << $urandom_range(8, 30)));
    end
    return it;
  endfunction

  task automatic queue_directed();
    iface_t it;
    iface_q.push_back(make_iface('0, '0, '0, '0, '0));                  // zero density
    iface_q.push_back(make_iface('1, '0, '0, '0, '1));
    iface_q.push_back(make_iface('1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1));
    iface_q.push_back(make_iface('1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
    iface_q.push_back(make_iface(RHO_W'(1), '0, '0, '0, '1));          // huge sound speed
    iface_q.push_back(make_iface(RHO_W'(1), 32'h7FFF_FFFF, '0, '0, '0)); // saturated eta
    iface_q.push_back(make_iface(RHO_W'(1), 32'h8000_0000, '0, '0, '1));
    iface_q.push_back(make_iface(RHO_W'(65536), 32'h0010_0000, '0, '0,
                                 31'h0000_1000));                       // ke > energy
    iface_q.push_back(make_iface(RHO_W'(65536), '0, '0, '0, 31'h0001_8000));
    iface_q.push_back(make_iface(RHO_W'(65536), 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000,
                                 31'h0004_0000));
    iface_q.push_back(make_iface(31'h4000_0000, 32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F,
                                 31'h5555_5555));
    iface_q.push_back(make_iface('0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 31'h1));
    it = make_iface(31'h0000_8000, 32'h0002_0000, '0, '0, 31'h0010_0000);
    it.rho_r = 31'h0004_0000; it.mx_r = 32'hFFF0_0000; it.en_r = 31'h7FFF_0000;
    iface_q.push_back(it);
    it.rho_l = '0; it.rho_r = '1; it.en_l = '1; it.en_r = '0;
    iface_q.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("error: %s got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // stream driver: loads the next pending interface after each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) eta_q.push_back(predict_eta(cur_iface));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (iface_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          cur_iface = iface_q.pop_front();
          s_axis_tdata  <= pack_iface(cur_iface);
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random and long back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (eta_q.size() == 0) report_mismatch("eta with none pending", m_axis_tdata, 0);
        else begin
          logic [ETA_W-1:0] want;
          want = eta_q.pop_front();
          if (m_axis_tdata !== OUT_DATA_W'(want))
            report_mismatch("eta_value", m_axis_tdata, want);
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)
        && !(cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // valid stays high across back to back writes, the caller drops it
  task automatic write_reg(reg_wr_t wr);
    cfg_index_i <= wr.idx;
    cfg_data_i  <= wr.data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    if (wr.idx == REG_GAMMA_RATIO) gamma_cur = wr.data;
    else if (wr.idx == REG_PRESSURE_FLOOR) floor_cur = wr.data[FLOOR_W-1:0];
  endtask

  // sample between edges so queue and valid updates have settled
  task automatic drain();
    while (iface_q.size() > 0 || s_axis_tvalid || eta_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  reg_wr_t setting[7][$];

  initial begin
    setting[1] = '{'{REG_GAMMA_RATIO, 19'd65537}, '{REG_PRESSURE_FLOOR, 19'd1}};
    setting[2] = '{'{REG_GAMMA_RATIO, 19'd327680}, '{REG_PRESSURE_FLOOR, 19'd65536}};
    setting[3] = '{'{REG_GAMMA_RATIO, 19'd65536}, '{REG_PRESSURE_FLOOR, 19'd100},
                   '{CFG_IDX_W'(2), 19'h5A5A5}, '{CFG_IDX_W'(3), 19'h7FFFF}};
    setting[4] = '{'{REG_GAMMA_RATIO, 19'h7FFFF}, '{REG_PRESSURE_FLOOR, 19'h1FFFF}};
    setting[5] = '{'{REG_GAMMA_RATIO, 19'd0}, '{REG_PRESSURE_FLOOR, 19'd0}};
    setting[6] = '{'{REG_GAMMA_RATIO, 19'd98304}, '{REG_PRESSURE_FLOOR, 19'd7}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 7; ph++) begin
      foreach (setting[ph][k]) write_reg(setting[ph][k]);
      cfg_valid_i <= 1'b0;
      case (ph % 3)
        0: begin src_idle = 30; sink_idle = 53; end
        1: begin src_idle = 53; sink_idle = 30; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      queue_directed();
      for (int n = 0; n < RAND_ITEMS; n++) iface_q.push_back(random_iface());
      if (ph == 2) begin
        // stall the output long enough for the pipeline to back up into the input
        repeat (20) @(posedge clk_i);
        hold_req++;
      end
      drain();
    end
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
